@@ rtl/core/mpr_pkg.sv @@
package mpr_pkg;

	// Matrix geometry
	localparam int MAX_SIZE = 12;
	localparam int CELLS    = MAX_SIZE * MAX_SIZE;
	localparam int AW       = $clog2(CELLS);
	localparam int SIZE_W   = 4;
	localparam int ROW_W    = $clog2(MAX_SIZE);
	localparam int MASK_W   = MAX_SIZE;
	localparam int SUB_W    = MAX_SIZE + 1;

	// Data widths
	localparam int ENTRY_W  = 16;
	localparam int MOD_W    = 31;
	localparam int SUM_W    = ENTRY_W + $clog2(MAX_SIZE + 1);
	localparam int BIT_W    = $clog2(SUM_W);

	// Register reset values
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(12);
	localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(1000000007);

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MATRIX_SIZE = 2'd0,
		CFG_MODULUS     = 2'd1
	} cfg_reg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             wr;
		logic [AW-1:0]    wr_addr;
		logic [AW-1:0]    rd_addr;
		logic             start;
		logic             subset;
		logic             upd;
		logic             add;
		logic [ROW_W-1:0] row;
		logic             mul;
		logic             mul_last;
		logic             acc;
		logic             acc_add;
		logic             out_load;
	} mpr_cmd_t;

	// Index of the lowest set bit (Gray code column to flip)
	function automatic logic [ROW_W-1:0] low_bit_index(input logic [MASK_W-1:0] v);
		logic [ROW_W-1:0] idx;
		idx = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = ROW_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ rtl/core/mpr_ram.sv @@
module mpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/mpr_dp.sv @@
module mpr_dp import mpr_pkg::*; (
	input  logic               clk,
	input  mpr_cmd_t           cmd,
	input  logic [ENTRY_W-1:0] entry_value,
	input  logic [MOD_W-1:0]   modulus,
	output logic [MOD_W-1:0]   result
);

	logic [ENTRY_W-1:0] rdata;
	logic [SUM_W-1:0]   rs_q [MAX_SIZE];
	logic [SUM_W-1:0]   rs_sel;
	logic [SUM_W-1:0]   rs_new;
	logic [SUM_W-1:0]   mq_q;
	logic [MOD_W-1:0]   res_q;
	logic [MOD_W-1:0]   prod_q;
	logic [MOD_W-1:0]   acc_q;
	logic [MOD_W-1:0]   out_q;
	logic [MOD_W:0]     dbl;
	logic [MOD_W-1:0]   dbl_red;
	logic [MOD_W:0]     addend;
	logic [MOD_W-1:0]   step_res;
	logic [MOD_W:0]     acc_sum;
	logic [MOD_W-1:0]   acc_next;

	// Matrix store
	mpr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(cmd.wr_addr),
		.wdata(entry_value),
		.raddr(cmd.rd_addr),
		.rdata(rdata)
	);

	// Gray code row sum update: column enters or leaves the subset
	assign rs_sel = rs_q[cmd.row];
	assign rs_new = cmd.add ? rs_sel + SUM_W'(rdata) : rs_sel - SUM_W'(rdata);

	// Shift-add modular multiply, multiplier MSB first
	assign dbl      = {res_q, 1'b0};
	assign dbl_red  = (dbl >= {1'b0, modulus}) ? MOD_W'(dbl - {1'b0, modulus}) : dbl[MOD_W-1:0];
	assign addend   = {1'b0, dbl_red} + (mq_q[SUM_W-1] ? {1'b0, prod_q} : '0);
	assign step_res = (addend >= {1'b0, modulus}) ? MOD_W'(addend - {1'b0, modulus})
	                                              : addend[MOD_W-1:0];

	// Signed accumulation of the subset product
	assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
	always_comb begin
		if (cmd.acc_add) begin
			acc_next = (acc_sum >= {1'b0, modulus}) ? MOD_W'(acc_sum - {1'b0, modulus})
			                                        : acc_sum[MOD_W-1:0];
		end else if (acc_q >= prod_q) begin
			acc_next = acc_q - prod_q;
		end else begin
			acc_next = MOD_W'({1'b0, acc_q} + {1'b0, modulus} - {1'b0, prod_q});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < MAX_SIZE; i++) begin
				rs_q[i] <= '0;
			end
			acc_q <= '0;
		end
		if (cmd.subset) begin
			prod_q <= (modulus == MOD_W'(1)) ? '0 : MOD_W'(1);
		end
		if (cmd.upd) begin
			rs_q[cmd.row] <= rs_new;
			mq_q          <= rs_new;
			res_q         <= '0;
		end
		if (cmd.mul) begin
			mq_q <= {mq_q[SUM_W-2:0], 1'b0};
			if (cmd.mul_last) begin
				prod_q <= step_res;
			end else begin
				res_q <= step_res;
			end
		end
		if (cmd.acc) begin
			acc_q <= acc_next;
		end
		if (cmd.out_load) begin
			out_q <= acc_q;
		end
	end

	assign result = out_q;

endmodule

@@ rtl/core/mpr_ctrl.sv @@
module mpr_ctrl import mpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] order,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mpr_cmd_t          cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_START,
		S_SUBSET,
		S_READ,
		S_UPDATE,
		S_MUL,
		S_ACC,
		S_PUT
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     cnt_q;
	logic [SUB_W-1:0]  sub_q;
	logic [MASK_W-1:0] gray_q;
	logic              add_q;
	logic [ROW_W-1:0]  row_q;
	logic [AW-1:0]     addr_q;
	logic [BIT_W-1:0]  bit_q;
	logic              out_valid_q;

	logic              accept;
	logic [AW:0]       cnt_inc;
	logic [AW-1:0]     nn;
	logic              load_done;
	logic [SUB_W-1:0]  sub_inc;
	logic              sub_end;
	logic [ROW_W-1:0]  col;
	logic              row_last;
	logic              bit_last;

	// Sequencing conditions
	assign accept    = in_valid && (state_q == S_LOAD);
	assign cnt_inc   = {1'b0, cnt_q} + (AW + 1)'(1);
	assign nn        = AW'(order) * AW'(order);
	assign load_done = cnt_inc >= {1'b0, nn};
	assign sub_inc   = sub_q + SUB_W'(1);
	assign sub_end   = sub_inc == (SUB_W'(1) << order);
	assign col       = low_bit_index(sub_inc[MASK_W-1:0]);
	assign row_last  = row_q == (ROW_W'(order) - ROW_W'(1));
	assign bit_last  = bit_q == BIT_W'(SUM_W - 1);

	// Commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.wr       = accept && (cnt_q < AW'(CELLS));
		cmd.wr_addr  = cnt_q;
		cmd.rd_addr  = addr_q;
		cmd.start    = state_q == S_START;
		cmd.subset   = (state_q == S_SUBSET) && !sub_end;
		cmd.upd      = state_q == S_UPDATE;
		cmd.add      = add_q;
		cmd.row      = row_q;
		cmd.mul      = state_q == S_MUL;
		cmd.mul_last = (state_q == S_MUL) && bit_last;
		cmd.acc      = state_q == S_ACC;
		cmd.acc_add  = order[0] == sub_q[0];
		cmd.out_load = (state_q == S_PUT) && (!out_valid_q || out_ready);
	end

	assign in_ready  = state_q == S_LOAD;
	assign out_valid = out_valid_q;

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			sub_q       <= '0;
			gray_q      <= '0;
			add_q       <= 1'b0;
			row_q       <= '0;
			addr_q      <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (load_done) begin
							cnt_q   <= '0;
							state_q <= S_START;
						end else begin
							cnt_q <= cnt_inc[AW-1:0];
						end
					end
				end
				S_START: begin
					sub_q   <= '0;
					gray_q  <= '0;
					state_q <= S_SUBSET;
				end
				S_SUBSET: begin
					if (sub_end) begin
						state_q <= S_PUT;
					end else begin
						sub_q       <= sub_inc;
						gray_q[col] <= ~gray_q[col];
						add_q       <= ~gray_q[col];
						row_q       <= '0;
						addr_q      <= AW'(col);
						state_q     <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					bit_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (bit_last) begin
						if (row_last) begin
							state_q <= S_ACC;
						end else begin
							row_q   <= row_q + ROW_W'(1);
							addr_q  <= addr_q + AW'(order);
							state_q <= S_READ;
						end
					end else begin
						bit_q <= bit_q + BIT_W'(1);
					end
				end
				S_ACC: begin
					state_q <= S_SUBSET;
				end
				S_PUT: begin
					if (cmd.out_load) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/matrix_permanent_ryser.sv @@
// Channel   Handshake                   Payload
// config    cfg_we                      cfg_index, cfg_wdata
// input     in_valid / in_ready         entry_value
// output    out_valid / out_ready       permanent_value
//
// Entries load one per cycle in row-major order into a 144-entry store.
// After the last of n*n entries the input stalls while the permanent is
// computed: one subset per Gray code step, and per row one store read, one
// row sum update and a 20-step shift-add modular multiplier, which sets the rate.
// A finished result waits in the output register; input stalls again only if
// the next result is ready before the previous one is taken.
// Reset clears control state; the matrix store holds no reset value.
module matrix_permanent_ryser import mpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [MOD_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ENTRY_W-1:0] entry_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [MOD_W-1:0]   permanent_value
);

	logic [SIZE_W-1:0] size_q;
	logic [MOD_W-1:0]  modulus_q;
	logic [SIZE_W-1:0] order;
	logic [MOD_W-1:0]  mod_eff;
	mpr_cmd_t          cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_RESET;
			modulus_q <= MOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MATRIX_SIZE: size_q    <= cfg_wdata[SIZE_W-1:0];
				CFG_MODULUS:     modulus_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective order and modulus
	assign order   = (size_q == '0) ? SIZE_W'(1) :
	                 (size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;
	assign mod_eff = (modulus_q < MOD_W'(2)) ? MOD_W'(1) : modulus_q;

	mpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.order    (order),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	mpr_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.entry_value(entry_value),
		.modulus    (mod_eff),
		.result     (permanent_value)
	);

	// Store writes only on an accepted input transaction
	a_wr_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (in_valid && in_ready))
		else $error("store write without input transaction");

	// No input accepted while the permanent is being computed
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd || cmd.mul || cmd.acc || cmd.start) |-> !in_ready)
		else $error("input ready during computation");

	// Loading a result always presents it the next cycle
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result loaded but not presented");

endmodule
